/* rtl/core/pts_pkg.sv */
package pts_pkg;

  localparam int TASK_SLOTS    = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int TIME_BITS     = 32;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
  localparam int PRIO_W = PRIORITY_BITS;
  localparam int CMP_W  = (PRIORITY_BITS > 8) ? PRIORITY_BITS : 8;
  localparam int TIME_W = TIME_BITS;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_TICK   = 2'd3
  } pts_req_type_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NONE   = 2'd2,
    STAT_UNUSED = 2'd3
  } pts_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GRANT,
    S_LOAD
  } pts_state_t;

  typedef struct packed {
    pts_req_type_t req_type;
    logic [3:0]    slot_id;
    logic [7:0]    base_priority;
    logic [7:0]    new_priority;
    logic [31:0]   due_time;
    logic [31:0]   now_time;
  } pts_req_t;

  typedef struct packed {
    pts_status_t status;
    logic [3:0]  slot_out;
    logic        granted;
  } pts_result_t;

endpackage

/* rtl/core/priority_task_scheduler_aging_top.sv */
// Priority task scheduler with aging.
// Request channel: a transaction is taken when start is high and busy is low.
// req_type selects add, remove, update or tick.
// Result channel: result_valid is high for exactly one cycle with the result;
// the receiver cannot stall it, so it must take every result as it comes.
// Add, remove and update finish in the accepting cycle; the result strobes
// on the next cycle and a new request may be taken in that same cycle.
// A tick scans the slot table through one shared compare and aging unit, one
// slot per cycle over a single-read priority/time memory port, then reads
// the winner's default priority and writes it back: busy stays high through
// S_SCAN, S_GRANT and S_LOAD when a task is granted and skips S_LOAD when
// no task is ready. The result strobes in the first cycle after busy falls,
// and a new request may be taken in that same cycle.
// Configuration: cfg_valid/cfg_ready/cfg_data write the sleep level;
// cfg_ready is always high. Write it only while the block is idle.
// Reset (rst, synchronous) frees every slot, clears the sleep level and
// returns to idle; task storage is not cleared and is written by add.
module priority_task_scheduler_aging_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pts_pkg::pts_req_t   req,
  output logic                result_valid,
  output pts_pkg::pts_result_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import pts_pkg::*;

  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

  logic [PRIO_W-1:0] prio_mem [TASK_SLOTS];
  logic [PRIO_W-1:0] base_mem [TASK_SLOTS];
  logic [TIME_W-1:0] due_mem  [TASK_SLOTS];

  pts_state_t        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              have, have_next;
  logic [SLOT_W-1:0] best, best_next;
  logic [PRIO_W-1:0] best_prio, best_prio_next;
  logic              pend_valid, pend_valid_next;
  logic [SLOT_W-1:0] pend_idx, pend_idx_next;
  logic              pend_used, pend_used_next;
  logic [TIME_W-1:0] now_t, now_t_next;
  logic [TASK_SLOTS-1:0] used, used_next;
  logic [7:0]        sleep_prio;
  logic              res_valid, res_valid_next;
  pts_result_t       res, res_next;

  logic              pw_en;
  logic [SLOT_W-1:0] pw_addr;
  logic [PRIO_W-1:0] pw_data;
  logic              bw_en;
  logic              dw_en;
  logic [SLOT_W-1:0] dw_addr;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] base_rd_addr;
  logic [PRIO_W-1:0] prio_q;
  logic [PRIO_W-1:0] base_q;
  logic [TIME_W-1:0] due_q;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              sid_ok;
  logic [SLOT_W-1:0] sid_idx;
  logic              elig;
  logic [PRIO_W-1:0] aged;

  assign busy         = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign result_valid = res_valid;
  assign result       = res;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign sid_idx = SLOT_W'(req.slot_id);
  assign sid_ok  = (int'(req.slot_id) < TASK_SLOTS) && used[sid_idx];
  assign elig    = pend_valid && pend_used
                   && (CMP_W'(prio_q) != CMP_W'(sleep_prio)) && (due_q < now_t);
  assign aged    = (best_prio < PRIO_MAX) ? best_prio + 1'b1 : best_prio;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    have_next       = have;
    best_next       = best;
    best_prio_next  = best_prio;
    pend_valid_next = 1'b0;
    pend_idx_next   = pend_idx;
    pend_used_next  = pend_used;
    now_t_next      = now_t;
    used_next       = used;
    res_valid_next  = 1'b0;
    res_next        = res;
    pw_en           = 1'b0;
    pw_addr         = best;
    pw_data         = aged;
    bw_en           = 1'b0;
    dw_en           = 1'b0;
    dw_addr         = free_idx;
    rd_addr         = '0;
    base_rd_addr    = best;
    case (state)
      S_IDLE: begin
        if (start) begin
          res_next.status   = STAT_OK;
          res_next.slot_out = '0;
          res_next.granted  = 1'b0;
          case (req.req_type)
            REQ_ADD: begin
              res_valid_next = 1'b1;
              if (free_found) begin
                used_next[free_idx] = 1'b1;
                pw_en             = 1'b1;
                pw_addr           = free_idx;
                pw_data           = PRIO_W'(req.base_priority);
                bw_en             = 1'b1;
                dw_en             = 1'b1;
                dw_addr           = free_idx;
                res_next.slot_out = 4'(free_idx);
              end else begin
                res_next.status = STAT_FULL;
              end
            end
            REQ_REMOVE: begin
              res_valid_next = 1'b1;
              if (sid_ok) begin
                used_next[sid_idx] = 1'b0;
              end else begin
                res_next.status = STAT_UNUSED;
              end
            end
            REQ_UPDATE: begin
              res_valid_next = 1'b1;
              if (sid_ok) begin
                pw_en   = 1'b1;
                pw_addr = sid_idx;
                pw_data = PRIO_W'(req.new_priority);
                dw_en   = 1'b1;
                dw_addr = sid_idx;
              end else begin
                res_next.status = STAT_UNUSED;
              end
            end
            default: begin
              state_next = S_SCAN;
              cnt_next   = '0;
              have_next  = 1'b0;
              now_t_next = TIME_W'(req.now_time);
            end
          endcase
        end
      end
      S_SCAN: begin
        if (cnt < CNT_W'(TASK_SLOTS)) begin
          rd_addr         = SLOT_W'(cnt);
          pend_valid_next = 1'b1;
          pend_idx_next   = SLOT_W'(cnt);
          pend_used_next  = used[SLOT_W'(cnt)];
          cnt_next        = cnt + 1'b1;
        end else begin
          state_next = S_GRANT;
        end
        if (elig) begin
          if (!have) begin
            have_next      = 1'b1;
            best_next      = pend_idx;
            best_prio_next = prio_q;
          end else if (prio_q > best_prio) begin
            pw_en          = 1'b1;
            best_next      = pend_idx;
            best_prio_next = prio_q;
          end
        end
      end
      S_GRANT: begin
        if (have) begin
          state_next = S_LOAD;
        end else begin
          state_next        = S_IDLE;
          res_valid_next    = 1'b1;
          res_next.status   = STAT_NONE;
          res_next.slot_out = '0;
          res_next.granted  = 1'b0;
        end
      end
      S_LOAD: begin
        pw_en             = 1'b1;
        pw_data           = base_q;
        state_next        = S_IDLE;
        res_valid_next    = 1'b1;
        res_next.status   = STAT_OK;
        res_next.slot_out = 4'(best);
        res_next.granted  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      sleep_prio <= '0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
      have       <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      used       <= used_next;
      res_valid  <= res_valid_next;
      pend_valid <= pend_valid_next;
      have       <= have_next;
      cnt        <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        sleep_prio <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    best      <= best_next;
    best_prio <= best_prio_next;
    pend_idx  <= pend_idx_next;
    pend_used <= pend_used_next;
    now_t     <= now_t_next;
    res       <= res_next;
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      prio_mem[pw_addr] <= pw_data;
    end
    if (bw_en) begin
      base_mem[free_idx] <= PRIO_W'(req.base_priority);
    end
    if (dw_en) begin
      due_mem[dw_addr] <= TIME_W'(req.due_time);
    end
    prio_q <= prio_mem[rd_addr];
    due_q  <= due_mem[rd_addr];
    base_q <= base_mem[base_rd_addr];
  end

`ifndef SYNTHESIS
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.granted |-> result.status == STAT_OK)
    else $error("grant with bad status");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || result_valid)
    else $error("accepted transaction made no progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt <= CNT_W'(TASK_SLOTS))
    else $error("scan counter out of range");

  a_best_used: assert property (@(posedge clk) disable iff (rst)
    state == S_GRANT && have |-> used[best])
    else $error("winner slot is free");

  a_load_after_grant: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> $past(state) == S_GRANT)
    else $error("load without grant");
`endif

endmodule

/* tb/sv/priority_task_scheduler_aging_top_test.sv */
`timescale 1ns / 100ps

module priority_task_scheduler_aging_top_test;
  import pts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_REQUEST,
    ACT_SET_SLEEP,
    ACT_DRAIN
  } act_kind_t;

  typedef struct {
    act_kind_t   kind;
    pts_req_t    req;
    logic [7:0]  sleep;
    int unsigned gap_pct;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pts_req_t    req = '0;
  logic        result_valid;
  pts_result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  stim_t       pending_ops[$];
  pts_result_t outcome_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned quiet = 0;

  logic              tab_used[TASK_SLOTS];
  logic [PRIO_W-1:0] tab_prio[TASK_SLOTS];
  logic [PRIO_W-1:0] tab_base[TASK_SLOTS];
  logic [TIME_W-1:0] tab_due[TASK_SLOTS];
  logic [7:0]        sleep_level = '0;

  priority_task_scheduler_aging_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic pts_result_t predict_schedule(pts_req_t r);
    pts_result_t res;
    logic        found;
    int          best;
    res = '0;
    res.status = STAT_OK;
    case (r.req_type)
      REQ_ADD: begin
        res.status = STAT_FULL;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!tab_used[i] && res.status == STAT_FULL) begin
            tab_used[i] = 1'b1;
            tab_base[i] = r.base_priority;
            tab_prio[i] = r.base_priority;
            tab_due[i] = r.due_time;
            res.status = STAT_OK;
            res.slot_out = 4'(i);
          end
        end
      end
      REQ_REMOVE, REQ_UPDATE: begin
        if (!tab_used[r.slot_id]) begin
          res.status = STAT_UNUSED;
        end else if (r.req_type == REQ_REMOVE) begin
          tab_used[r.slot_id] = 1'b0;
        end else begin
          tab_prio[r.slot_id] = r.new_priority;
          tab_due[r.slot_id] = r.due_time;
        end
      end
      default: begin
        found = 1'b0;
        best = 0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (tab_used[i] && tab_prio[i] != sleep_level && tab_due[i] < r.now_time) begin
            if (!found) begin
              found = 1'b1;
              best = i;
            end else if (tab_prio[i] > tab_prio[best]) begin
              if (tab_prio[best] != PRIO_MAX) tab_prio[best] = tab_prio[best] + 1'b1;
              best = i;
            end
          end
        end
        if (found) begin
          tab_prio[best] = tab_base[best];
          res.slot_out = 4'(best);
          res.granted = 1'b1;
        end else begin
          res.status = STAT_NONE;
        end
      end
    endcase
    return res;
  endfunction

  function automatic pts_req_t make_req(pts_req_type_t kind, int unsigned slot,
                                        int unsigned base, int unsigned prio,
                                        logic [31:0] due, logic [31:0] now);
    pts_req_t r;
    r.req_type = kind;
    r.slot_id = 4'(slot);
    r.base_priority = 8'(base);
    r.new_priority = 8'(prio);
    r.due_time = due;
    r.now_time = now;
    return r;
  endfunction

  function automatic logic [7:0] rand_prio();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8));
  endfunction

  function automatic logic [31:0] rand_time(int unsigned span);
    return ($urandom_range(3) == 0) ? 32'($urandom()) : 32'($urandom_range(span));
  endfunction

  function automatic pts_req_t rand_req(int unsigned add_pct);
    pts_req_t    r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.slot_id = 4'($urandom_range(15));
    r.base_priority = rand_prio();
    r.new_priority = rand_prio();
    r.due_time = rand_time(60);
    r.now_time = rand_time(70);
    if (pick < add_pct) r.req_type = REQ_ADD;
    else if (pick < add_pct + 15) r.req_type = REQ_REMOVE;
    else if (pick < add_pct + 35) r.req_type = REQ_UPDATE;
    else r.req_type = REQ_TICK;
    return r;
  endfunction

  task automatic queue_req(pts_req_t r, int unsigned gap);
    stim_t s;
    s.kind = ACT_REQUEST;
    s.req = r;
    s.sleep = '0;
    s.gap_pct = gap;
    pending_ops.push_back(s);
  endtask

  task automatic queue_act(act_kind_t kind, logic [7:0] sleep);
    stim_t s;
    s.kind = kind;
    s.req = '0;
    s.sleep = sleep;
    s.gap_pct = 0;
    pending_ops.push_back(s);
  endtask

  initial begin : fill_stimulus
    logic [7:0]  sleep_plan[PHASES];
    int unsigned add_plan[PHASES];
    int unsigned gap_plan[4];
    for (int i = 0; i < TASK_SLOTS; i++) begin
      tab_used[i] = 1'b0;
      tab_prio[i] = '0;
      tab_base[i] = '0;
      tab_due[i] = '0;
    end
    sleep_plan = '{8'hFF, 8'd3, 8'($urandom_range(255)), 8'd0, 8'd1, 8'h80,
                   8'($urandom_range(255)), 8'd5};
    add_plan = '{45, 30, 25, 40, 30, 50, 25, 35};
    gap_plan = '{0, 53, 0, 25};

    queue_req(make_req(REQ_TICK, 0, 0, 0, 0, 100), 0);
    queue_req(make_req(REQ_REMOVE, 0, 0, 0, 0, 0), 0);
    queue_req(make_req(REQ_UPDATE, 15, 0, 9, 0, 0), 0);
    queue_req(make_req(REQ_ADD, 0, 0, 0, 0, 0), 0);
    queue_req(make_req(REQ_ADD, 0, 255, 0, 32'hFFFF_FFFF, 0), 0);
    queue_req(make_req(REQ_ADD, 0, 5, 0, 10, 0), 0);
    queue_req(make_req(REQ_ADD, 0, 5, 0, 10, 0), 0);
    queue_req(make_req(REQ_ADD, 0, 7, 0, 9, 0), 0);
    queue_req(make_req(REQ_TICK, 0, 0, 0, 0, 10), 0);
    queue_req(make_req(REQ_TICK, 0, 0, 0, 0, 11), 0);
    queue_req(make_req(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF), 0);
    queue_req(make_req(REQ_UPDATE, 4, 0, 0, 0, 0), 0);
    queue_req(make_req(REQ_UPDATE, 1, 0, 200, 0, 0), 0);
    queue_req(make_req(REQ_TICK, 0, 0, 0, 0, 0), 0);
    queue_req(make_req(REQ_TICK, 0, 0, 0, 0, 1), 0);
    queue_req(make_req(REQ_REMOVE, 3, 0, 0, 0, 0), 0);
    queue_req(make_req(REQ_REMOVE, 3, 0, 0, 0, 0), 0);
    for (int i = 0; i < 14; i++) begin
      queue_req(make_req(REQ_ADD, 0, 250 + i % 6, 0, 32'h8000_0000 + i, 0), 0);
    end

    for (int p = 0; p < PHASES; p++) begin
      queue_act(ACT_SET_SLEEP, sleep_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) queue_act(ACT_DRAIN, '0);
        queue_req(rand_req(add_plan[p]), gap_plan[p % 4]);
      end
    end
  end

  always @(posedge clk) begin : drive
    logic        start_nx;
    logic        cfg_nx;
    int unsigned quiet_nx;
    stim_t       op;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      quiet <= 0;
    end else begin
      start_nx = start;
      cfg_nx = cfg_valid;
      if (start && !busy) begin
        outcome_q.push_back(predict_schedule(req));
        start_nx = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        sleep_level = cfg_data;
        cfg_nx = 1'b0;
      end
      quiet_nx = (outcome_q.size() == 0 && !busy && !start && !cfg_valid) ? quiet + 1 : 0;
      if (!start_nx && !cfg_nx && pending_ops.size() != 0) begin
        op = pending_ops[0];
        case (op.kind)
          ACT_REQUEST: begin
            if ($urandom_range(99) >= op.gap_pct) begin
              start_nx = 1'b1;
              req <= op.req;
              void'(pending_ops.pop_front());
            end
          end
          ACT_SET_SLEEP: begin
            if (quiet >= SETTLE_CYCLES) begin
              cfg_nx = 1'b1;
              cfg_data <= op.sleep;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (quiet >= SETTLE_CYCLES) void'(pending_ops.pop_front());
          end
        endcase
      end
      start <= start_nx;
      cfg_valid <= cfg_nx;
      quiet <= quiet_nx;
    end
  end

  always @(posedge clk) begin : check
    pts_result_t want;
    if (!rst && result_valid) begin
      if (outcome_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("%0t: result with no transaction pending: status %0d slot %0d granted %0d",
                   $realtime, result.status, result.slot_out, result.granted);
        fail_cnt++;
      end else begin
        want = outcome_q.pop_front();
        if (result.status !== want.status || result.slot_out !== want.slot_out ||
            result.granted !== want.granted) begin
          if (fail_cnt < 10)
            $display("%0t: mismatch: want status %0d slot %0d granted %0d, got %0d %0d %0d",
                     $realtime, want.status, want.slot_out, want.granted,
                     result.status, result.slot_out, result.granted);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : finish_run
    @(posedge clk);
    while (rst || pending_ops.size() != 0 || start || cfg_valid) @(posedge clk);
    while (outcome_q.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
